>>> hdl/rvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvd_pkg
// Opcode, operation and unit codes plus the decoded-result type for the
// RV32IM instruction decoder.
// ----------------------------------------------------------------------------
package rvd_pkg;

	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_FENCE  = 7'h0F;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] SLLI_F7_MASK = 7'h7E;
	localparam logic [6:0] SRXI_F7_MASK = 7'h5F;
	localparam logic [6:0] F7_BASE      = 7'h00;
	localparam logic [6:0] F7_MULDIV    = 7'h01;
	localparam logic [6:0] F7_ALT       = 7'h20;

	localparam logic [2:0] F3_ADD_SUB = 3'd0;
	localparam logic [2:0] F3_SLL     = 3'd1;
	localparam logic [2:0] F3_SRL_SRA = 3'd5;
	localparam logic [2:0] F3_FENCE_I = 3'd1;

	typedef enum logic [5:0] {
		OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_JAL = 6'd2, OP_JALR = 6'd3,
		OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLT = 6'd6, OP_BGE = 6'd7,
		OP_BLTU = 6'd8, OP_BGEU = 6'd9,
		OP_LB = 6'd10, OP_LH = 6'd11, OP_LW = 6'd12, OP_LBU = 6'd13, OP_LHU = 6'd14,
		OP_SB = 6'd15, OP_SH = 6'd16, OP_SW = 6'd17,
		OP_ADD = 6'd18, OP_SUB = 6'd19, OP_SLL = 6'd20, OP_SLT = 6'd21,
		OP_SLTU = 6'd22, OP_XOR = 6'd23, OP_SRL = 6'd24, OP_SRA = 6'd25,
		OP_OR = 6'd26, OP_AND = 6'd27,
		OP_MUL = 6'd28, OP_MULH = 6'd29, OP_MULHSU = 6'd30, OP_MULHU = 6'd31,
		OP_DIV = 6'd32, OP_DIVU = 6'd33, OP_REM = 6'd34, OP_REMU = 6'd35,
		OP_FENCE = 6'd36, OP_FENCE_I = 6'd37, OP_ECALL = 6'd38, OP_EBREAK = 6'd39,
		OP_INVALID = 6'd40
	} op_t;

	typedef enum logic [2:0] {
		KIND_ALU = 3'd0, KIND_BRANCH = 3'd1, KIND_LOAD = 3'd2, KIND_STORE = 3'd3,
		KIND_MUL = 3'd4, KIND_DIV = 3'd5, KIND_NOP = 3'd6, KIND_TRAP = 3'd7
	} kind_t;

	typedef struct packed {
		op_t                op;
		kind_t              kind;
		logic [4:0]         rd;
		logic [4:0]         rs1;
		logic [4:0]         rs2;
		logic signed [31:0] imm;
		logic               wr;
		logic               br;
		logic               ld;
		logic               st;
		logic [31:0]        raw;
	} dec_t;

	function automatic op_t branch_op(input logic [2:0] f3);
		case (f3)
			3'd0:    branch_op = OP_BEQ;
			3'd1:    branch_op = OP_BNE;
			3'd4:    branch_op = OP_BLT;
			3'd5:    branch_op = OP_BGE;
			3'd6:    branch_op = OP_BLTU;
			3'd7:    branch_op = OP_BGEU;
			default: branch_op = OP_INVALID;
		endcase
	endfunction

	function automatic op_t load_op(input logic [2:0] f3);
		case (f3)
			3'd0:    load_op = OP_LB;
			3'd1:    load_op = OP_LH;
			3'd2:    load_op = OP_LW;
			3'd4:    load_op = OP_LBU;
			3'd5:    load_op = OP_LHU;
			default: load_op = OP_INVALID;
		endcase
	endfunction

	function automatic op_t store_op(input logic [2:0] f3);
		case (f3)
			3'd0:    store_op = OP_SB;
			3'd1:    store_op = OP_SH;
			3'd2:    store_op = OP_SW;
			default: store_op = OP_INVALID;
		endcase
	endfunction

	// shared by OP and OP-IMM; shift slots only meaningful for OP
	function automatic op_t alu_op(input logic [2:0] f3);
		case (f3)
			3'd0:    alu_op = OP_ADD;
			3'd1:    alu_op = OP_SLL;
			3'd2:    alu_op = OP_SLT;
			3'd3:    alu_op = OP_SLTU;
			3'd4:    alu_op = OP_XOR;
			3'd5:    alu_op = OP_SRL;
			3'd6:    alu_op = OP_OR;
			default: alu_op = OP_AND;
		endcase
	endfunction

	function automatic op_t muldiv_op(input logic [2:0] f3);
		case (f3)
			3'd0:    muldiv_op = OP_MUL;
			3'd1:    muldiv_op = OP_MULH;
			3'd2:    muldiv_op = OP_MULHSU;
			3'd3:    muldiv_op = OP_MULHU;
			3'd4:    muldiv_op = OP_DIV;
			3'd5:    muldiv_op = OP_DIVU;
			3'd6:    muldiv_op = OP_REM;
			default: muldiv_op = OP_REMU;
		endcase
	endfunction

endpackage

>>> hdl/rvd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvd_req_if
// Instruction channel: valid/ready plus the raw instruction word.
// ----------------------------------------------------------------------------
interface rvd_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;

	modport source (output valid, output instr_word, input ready);
	modport sink   (input valid, input instr_word, output ready);
endinterface

>>> hdl/rvd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvd_rsp_if
// Decoded-instruction channel: valid/ready plus the decoded fields.
// ----------------------------------------------------------------------------
interface rvd_rsp_if;
	logic               valid;
	logic               ready;
	logic [5:0]         op_code;
	logic [2:0]         unit_kind;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic signed [31:0] immediate;
	logic               writes_dest;
	logic               branch_flag;
	logic               load_flag;
	logic               store_flag;
	logic [31:0]        raw_echo;

	modport source (
		output valid, input ready,
		output op_code, output unit_kind, output dest_reg, output src1_reg,
		output src2_reg, output immediate, output writes_dest, output branch_flag,
		output load_flag, output store_flag, output raw_echo
	);
	modport sink (
		input valid, output ready,
		input op_code, input unit_kind, input dest_reg, input src1_reg,
		input src2_reg, input immediate, input writes_dest, input branch_flag,
		input load_flag, input store_flag, input raw_echo
	);
endinterface

>>> hdl/rvd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvd_decode
// Combinational RV32IM decode of one instruction word into dec_t.
// ----------------------------------------------------------------------------
module rvd_decode
	import rvd_pkg::*;
(
	input  logic [31:0] word,
	output dec_t        dec
);

	logic [6:0] opc;
	logic [2:0] f3;
	logic [6:0] f7;
	logic signed [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

	assign opc = word[6:0];
	assign f3  = word[14:12];
	assign f7  = word[31:25];

	assign imm_i = {{20{word[31]}}, word[31:20]};
	assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
	assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
	assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
	assign imm_u = {word[31:12], 12'd0};

	dec_t d;

	always_comb begin
		d      = '0;
		d.op   = OP_INVALID;
		d.kind = KIND_TRAP;
		d.rd   = word[11:7];
		d.rs1  = word[19:15];
		d.rs2  = word[24:20];
		d.raw  = word;

		case (opc)
			OPC_LUI, OPC_AUIPC: begin
				d.op   = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
				d.kind = KIND_ALU;
				d.imm  = imm_u;
				d.rs1  = '0;
				d.rs2  = '0;
				d.wr   = 1'b1;
			end
			OPC_JAL: begin
				d.op   = OP_JAL;
				d.kind = KIND_BRANCH;
				d.imm  = imm_j;
				d.rs1  = '0;
				d.rs2  = '0;
				d.br   = 1'b1;
				d.wr   = 1'b1;
			end
			OPC_JALR: begin
				if (f3 == F3_ADD_SUB) begin
					d.op   = OP_JALR;
					d.kind = KIND_BRANCH;
					d.imm  = imm_i;
					d.rs2  = '0;
					d.br   = 1'b1;
					d.wr   = 1'b1;
				end
			end
			OPC_BRANCH: begin
				d.op   = branch_op(f3);
				d.kind = KIND_BRANCH;
				d.imm  = imm_b;
				d.rd   = '0;
				d.br   = 1'b1;
			end
			OPC_LOAD: begin
				d.op   = load_op(f3);
				d.kind = KIND_LOAD;
				d.imm  = imm_i;
				d.rs2  = '0;
				d.ld   = 1'b1;
				d.wr   = 1'b1;
			end
			OPC_STORE: begin
				d.op   = store_op(f3);
				d.kind = KIND_STORE;
				d.imm  = imm_s;
				d.rd   = '0;
				d.st   = 1'b1;
			end
			OPC_OPIMM: begin
				d.kind = KIND_ALU;
				d.rs2  = '0;
				d.wr   = 1'b1;
				case (f3)
					F3_SLL: begin
						d.imm = {27'd0, word[24:20]};
						if ((f7 & SLLI_F7_MASK) == F7_BASE)
							d.op = OP_SLL;
					end
					F3_SRL_SRA: begin
						d.imm = {27'd0, word[24:20]};
						if ((f7 & SRXI_F7_MASK) == F7_BASE)
							d.op = f7[5] ? OP_SRA : OP_SRL;
					end
					default: begin
						d.imm = imm_i;
						d.op  = alu_op(f3);
					end
				endcase
			end
			OPC_OP: begin
				d.wr = 1'b1;
				if (f7 == F7_MULDIV) begin
					d.op   = muldiv_op(f3);
					d.kind = f3[2] ? KIND_DIV : KIND_MUL;
				end else if (f7 == F7_BASE) begin
					d.op   = alu_op(f3);
					d.kind = KIND_ALU;
				end else if (f7 == F7_ALT && f3 == F3_ADD_SUB) begin
					d.op   = OP_SUB;
					d.kind = KIND_ALU;
				end else if (f7 == F7_ALT && f3 == F3_SRL_SRA) begin
					d.op   = OP_SRA;
					d.kind = KIND_ALU;
				end
			end
			OPC_FENCE: begin
				if (f3 inside {F3_ADD_SUB, F3_FENCE_I}) begin
					d.op   = (f3 == F3_FENCE_I) ? OP_FENCE_I : OP_FENCE;
					d.kind = KIND_NOP;
					d.rd   = '0;
					d.rs1  = '0;
					d.rs2  = '0;
				end
			end
			OPC_SYSTEM: begin
				if (f3 == F3_ADD_SUB && word[31:21] == 11'd0) begin
					d.op   = word[20] ? OP_EBREAK : OP_ECALL;
					d.kind = KIND_TRAP;
					d.rd   = '0;
					d.rs1  = '0;
					d.rs2  = '0;
				end
			end
			default: ;
		endcase

		// unknown encodings keep only the raw word
		if (d.op == OP_INVALID) begin
			d      = '0;
			d.op   = OP_INVALID;
			d.kind = KIND_TRAP;
			d.raw  = word;
		end
		if (d.rd == 5'd0)
			d.wr = 1'b0;
	end

	assign dec = d;

endmodule

>>> hdl/rv32im_instruction_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_top
// RV32IM instruction decoder: input register, decode logic, result register.
//
//   channel   dir   payload
//   req       in    instr_word
//   rsp       out   op_code, unit_kind, dest/src regs, immediate, flags, raw_echo
//
// An accepted req beat passes the input register, then the result register,
// to rsp; one beat per cycle sustained while rsp is ready. The registers form
// a two-deep pipeline, so req stays ready while a result waits on a stalled
// rsp until both stages are full. Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_top
	import rvd_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	rvd_req_if.sink   req,
	rvd_rsp_if.source rsp
);

	logic        v_s1;
	logic [31:0] instr_s1;
	logic        v_s2;
	dec_t        dec_s2;
	dec_t        dec_comb;
	logic        open_s2;

	assign open_s2   = !v_s2 || rsp.ready;
	assign req.ready = !v_s1 || open_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid)
			instr_s1 <= req.instr_word;
	end

	rvd_decode u_decode (
		.word (instr_s1),
		.dec  (dec_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (open_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (open_s2 && v_s1)
			dec_s2 <= dec_comb;
	end

	assign rsp.valid       = v_s2;
	assign rsp.op_code     = dec_s2.op;
	assign rsp.unit_kind   = dec_s2.kind;
	assign rsp.dest_reg    = dec_s2.rd;
	assign rsp.src1_reg    = dec_s2.rs1;
	assign rsp.src2_reg    = dec_s2.rs2;
	assign rsp.immediate   = dec_s2.imm;
	assign rsp.writes_dest = dec_s2.wr;
	assign rsp.branch_flag = dec_s2.br;
	assign rsp.load_flag   = dec_s2.ld;
	assign rsp.store_flag  = dec_s2.st;
	assign rsp.raw_echo    = dec_s2.raw;

endmodule
